// ----- hdl/thick_line_rasterizer_macros.svh -----
// assertion macros for the line rasterizer
`ifndef THICK_LINE_RASTERIZER_MACROS_SVH
`define THICK_LINE_RASTERIZER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TLR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tlr_pkg.sv -----
package tlr_pkg;

    localparam int COORD_BITS    = 12;
    localparam int POS_BITS      = COORD_BITS + 1;
    localparam int ERR_BITS      = POS_BITS + 2;
    localparam int FRAME_BITS    = 12;
    localparam int ADDR_BITS     = 22;
    localparam int COLOR_BITS    = 16;
    localparam int THICK_BITS    = 3;
    localparam int HALF_BITS     = 2;
    localparam int STAMP_BITS    = HALF_BITS + 1;
    localparam int MAX_THICKNESS = 7;
    localparam int FRAME_RESET   = 240;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  pixel_address;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  write_enable;
        logic                  line_done;
    } t_result;

endpackage

// ----- hdl/thick_line_rasterizer.sv -----
// a step's pixel write enters the output register, or the skid stage on a stall
// throughput: one transaction per cycle while the skid stage is empty; output
//   register plus skid stage take one more transaction while a result is stalled
// loads and steps without an active line produce no result
// reset (synchronous, active low): no line active, outputs empty, frame 240 x 240
`include "thick_line_rasterizer_macros.svh"

module thick_line_rasterizer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [tlr_pkg::FRAME_BITS-1:0]       i_cfg_data,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_opcode,
    input  logic signed [tlr_pkg::COORD_BITS-1:0] i_x_start,
    input  logic signed [tlr_pkg::COORD_BITS-1:0] i_y_start,
    input  logic signed [tlr_pkg::COORD_BITS-1:0] i_x_end,
    input  logic signed [tlr_pkg::COORD_BITS-1:0] i_y_end,
    input  logic signed [tlr_pkg::COORD_BITS-1:0] i_x_shift,
    input  logic signed [tlr_pkg::COORD_BITS-1:0] i_y_shift,
    input  logic [7:0]                           i_red,
    input  logic [7:0]                           i_green,
    input  logic [7:0]                           i_blue,
    input  logic [tlr_pkg::THICK_BITS-1:0]       i_thickness,
    input  logic                                 i_swap_bytes,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tlr_pkg::ADDR_BITS-1:0]        o_pixel_address,
    output logic [tlr_pkg::COLOR_BITS-1:0]       o_pixel_color,
    output logic                                 o_write_enable,
    output logic                                 o_line_done
);

    import tlr_pkg::*;

    localparam int PROD_BITS = COORD_BITS + FRAME_BITS;
    localparam int CMP_BITS  = ERR_BITS + 2;

    // configuration
    logic [FRAME_BITS-1:0] r_frame_width;
    logic [FRAME_BITS-1:0] r_frame_height;

    // line state
    logic signed [POS_BITS-1:0] r_cur_x, r_cur_y, r_end_x, r_end_y;
    logic signed [POS_BITS-1:0] n_cur_x, n_cur_y, n_end_x, n_end_y;
    logic [POS_BITS-1:0]        r_delta_x, r_delta_y, n_delta_x, n_delta_y;
    logic                       r_dir_x_neg, r_dir_y_neg, n_dir_x_neg, n_dir_y_neg;
    logic signed [ERR_BITS-1:0] r_error, n_error;
    logic [STAMP_BITS-1:0]      r_stamp_dx, r_stamp_dy, n_stamp_dx, n_stamp_dy;
    logic [HALF_BITS-1:0]       r_half, n_half;
    logic [COLOR_BITS-1:0]      r_color, n_color;
    logic                       r_active, n_active;

    // output register and skid stage
    t_result r_out, n_out, r_skid, n_skid;
    logic    r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;

    logic in_accept, step_accept, load_accept, res_new, out_free;
    t_result w_res;

    // load path
    logic signed [POS_BITS-1:0] w_x1, w_y1, w_x2, w_y2;
    logic [COLOR_BITS-1:0]      w_packed;
    logic [THICK_BITS-1:0]      w_thick;

    // step path
    logic [STAMP_BITS-1:0]      w_side;
    logic signed [STAMP_BITS:0] w_off_x, w_off_y;
    logic signed [POS_BITS:0]   w_px, w_py;
    logic                       w_inside, w_last_stamp, w_at_end, w_done;
    logic [PROD_BITS-1:0]       w_prod;
    logic signed [CMP_BITS-1:0] w_e2, w_dx_ext, w_dy_ext;
    logic                       w_move_x, w_move_y;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;

    assign in_accept   = i_in_valid && o_in_ready;
    assign load_accept = in_accept && (t_opcode'(i_opcode) == OP_LOAD);
    assign step_accept = in_accept && (t_opcode'(i_opcode) == OP_STEP) && r_active;
    assign res_new     = step_accept;
    assign out_free    = !r_out_valid || i_out_ready;

    // load arithmetic
    always_comb begin
        w_x1 = POS_BITS'(i_x_start) + POS_BITS'(i_x_shift);
        w_y1 = POS_BITS'(i_y_start) + POS_BITS'(i_y_shift);
        w_x2 = POS_BITS'(i_x_end) + POS_BITS'(i_x_shift);
        w_y2 = POS_BITS'(i_y_end) + POS_BITS'(i_y_shift);
        w_packed = {i_red[7:3], i_green[7:2], i_blue[7:3]};
        if (i_swap_bytes) begin
            w_packed = {w_packed[7:0], w_packed[15:8]};
        end
        w_thick = i_thickness;
        if (w_thick > THICK_BITS'(MAX_THICKNESS)) begin
            w_thick = THICK_BITS'(MAX_THICKNESS);
        end
    end

    // stamp pixel and bresenham step
    always_comb begin
        w_side  = {r_half, 1'b0};
        w_off_x = $signed({1'b0, r_stamp_dx}) - $signed((STAMP_BITS+1)'(r_half));
        w_off_y = $signed({1'b0, r_stamp_dy}) - $signed((STAMP_BITS+1)'(r_half));
        w_px    = (POS_BITS+1)'(r_cur_x) + (POS_BITS+1)'(w_off_x);
        w_py    = (POS_BITS+1)'(r_cur_y) + (POS_BITS+1)'(w_off_y);

        w_inside = !w_px[POS_BITS] && !w_py[POS_BITS]
                && (w_px[POS_BITS-1:0] < POS_BITS'(r_frame_width))
                && (w_py[POS_BITS-1:0] < POS_BITS'(r_frame_height));

        w_prod = PROD_BITS'(w_py[COORD_BITS-1:0]) * PROD_BITS'(r_frame_width);

        w_res.pixel_address = '0;
        if (w_inside) begin
            w_res.pixel_address = ADDR_BITS'(w_prod + PROD_BITS'(w_px[COORD_BITS-1:0]));
        end
        w_res.pixel_color  = r_color;
        w_res.write_enable = w_inside;

        w_last_stamp = (r_stamp_dx == w_side) && (r_stamp_dy == w_side);
        w_at_end     = (r_cur_x == r_end_x) && (r_cur_y == r_end_y);
        w_done       = w_last_stamp && w_at_end;
        w_res.line_done = w_done;

        w_e2     = CMP_BITS'(r_error) <<< 1;
        w_dx_ext = $signed(CMP_BITS'(r_delta_x));
        w_dy_ext = $signed(CMP_BITS'(r_delta_y));
        w_move_x = w_e2 > -w_dy_ext;
        w_move_y = w_e2 < w_dx_ext;
    end

    // state next values
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_end_x     = r_end_x;
        n_end_y     = r_end_y;
        n_delta_x   = r_delta_x;
        n_delta_y   = r_delta_y;
        n_dir_x_neg = r_dir_x_neg;
        n_dir_y_neg = r_dir_y_neg;
        n_error     = r_error;
        n_stamp_dx  = r_stamp_dx;
        n_stamp_dy  = r_stamp_dy;
        n_half      = r_half;
        n_color     = r_color;
        n_active    = r_active;

        if (load_accept) begin
            n_cur_x     = w_x1;
            n_cur_y     = w_y1;
            n_end_x     = w_x2;
            n_end_y     = w_y2;
            n_delta_x   = (w_x2 >= w_x1) ? unsigned'(w_x2 - w_x1) : unsigned'(w_x1 - w_x2);
            n_delta_y   = (w_y2 >= w_y1) ? unsigned'(w_y2 - w_y1) : unsigned'(w_y1 - w_y2);
            n_dir_x_neg = !(w_x1 < w_x2);
            n_dir_y_neg = !(w_y1 < w_y2);
            n_error     = $signed(ERR_BITS'(n_delta_x)) - $signed(ERR_BITS'(n_delta_y));
            n_half      = HALF_BITS'(w_thick >> 1);
            n_stamp_dx  = '0;
            n_stamp_dy  = '0;
            n_color     = w_packed;
            n_active    = 1'b1;
        end else if (step_accept) begin
            if (r_stamp_dx < w_side) begin
                n_stamp_dx = r_stamp_dx + 1'b1;
            end else begin
                n_stamp_dx = '0;
                if (r_stamp_dy < w_side) begin
                    n_stamp_dy = r_stamp_dy + 1'b1;
                end else begin
                    n_stamp_dy = '0;
                end
            end
            if (w_done) begin
                n_active = 1'b0;
            end else if (w_last_stamp) begin
                n_error = r_error
                        - (w_move_x ? $signed(ERR_BITS'(r_delta_y)) : '0)
                        + (w_move_y ? $signed(ERR_BITS'(r_delta_x)) : '0);
                if (w_move_x) begin
                    n_cur_x = r_dir_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                end
                if (w_move_y) begin
                    n_cur_y = r_dir_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                end
            end
        end
    end

    // output register and skid next values
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (res_new) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (res_new) begin
            n_skid       = w_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_BITS'(FRAME_RESET);
            r_frame_height <= FRAME_BITS'(FRAME_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_stamp_dx   <= '0;
            r_stamp_dy   <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_stamp_dx   <= n_stamp_dx;
            r_stamp_dy   <= n_stamp_dy;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_end_x     <= n_end_x;
        r_end_y     <= n_end_y;
        r_delta_x   <= n_delta_x;
        r_delta_y   <= n_delta_y;
        r_dir_x_neg <= n_dir_x_neg;
        r_dir_y_neg <= n_dir_y_neg;
        r_error     <= n_error;
        r_half      <= n_half;
        r_color     <= n_color;
        r_out       <= n_out;
        r_skid      <= n_skid;
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_address = r_out.pixel_address;
    assign o_pixel_color   = r_out.pixel_color;
    assign o_write_enable  = r_out.write_enable;
    assign o_line_done     = r_out.line_done;

    `TLR_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid, "skid holds data with empty output")
    `TLR_ASSERT_SAME(a_stamp_bounded, r_active, (r_stamp_dx <= w_side) && (r_stamp_dy <= w_side), "stamp counter past side")
    `TLR_ASSERT_NEXT(a_done_ends_line, step_accept && w_done, !r_active, "line still active after last pixel")
    `TLR_ASSERT_NEXT(a_load_arms, load_accept, r_active && (r_stamp_dx == '0) && (r_stamp_dy == '0), "load did not arm line")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tlr_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        t_opcode                      opcode;
        logic signed [COORD_BITS-1:0] x_start;
        logic signed [COORD_BITS-1:0] y_start;
        logic signed [COORD_BITS-1:0] x_end;
        logic signed [COORD_BITS-1:0] y_end;
        logic signed [COORD_BITS-1:0] x_shift;
        logic signed [COORD_BITS-1:0] y_shift;
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
        logic [THICK_BITS-1:0]        thickness;
        logic                         swap_bytes;
    } t_raster_cmd;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic                         i_cfg_index;
    logic [FRAME_BITS-1:0]        i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic                         i_opcode;
    logic signed [COORD_BITS-1:0] i_x_start;
    logic signed [COORD_BITS-1:0] i_y_start;
    logic signed [COORD_BITS-1:0] i_x_end;
    logic signed [COORD_BITS-1:0] i_y_end;
    logic signed [COORD_BITS-1:0] i_x_shift;
    logic signed [COORD_BITS-1:0] i_y_shift;
    logic [7:0]                   i_red;
    logic [7:0]                   i_green;
    logic [7:0]                   i_blue;
    logic [THICK_BITS-1:0]        i_thickness;
    logic                         i_swap_bytes;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [ADDR_BITS-1:0]         o_pixel_address;
    logic [COLOR_BITS-1:0]        o_pixel_color;
    logic                         o_write_enable;
    logic                         o_line_done;

    // rasterizer state as the bench sees it
    logic [FRAME_BITS-1:0]        fb_width;
    logic [FRAME_BITS-1:0]        fb_height;
    logic signed [POS_BITS-1:0]   pos_x;
    logic signed [POS_BITS-1:0]   pos_y;
    logic signed [POS_BITS-1:0]   goal_x;
    logic signed [POS_BITS-1:0]   goal_y;
    logic [POS_BITS-1:0]          run_x;
    logic [POS_BITS-1:0]          run_y;
    logic                         step_x_neg;
    logic                         step_y_neg;
    logic signed [ERR_BITS-1:0]   err_acc;
    logic [STAMP_BITS-1:0]        col_cnt;
    logic [STAMP_BITS-1:0]        row_cnt;
    logic [HALF_BITS-1:0]         half;
    logic [COLOR_BITS-1:0]        color_reg;
    logic                         drawing;

    t_result pixel_writes_due[$];
    t_result got;
    t_result want;
    int      mismatch_count;
    int      work_items;
    int      quiet_cycles;
    int      hold_len;
    bit      tx_idle_en;
    bit      rx_idle_en;

    thick_line_rasterizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_x_start       (i_x_start),
        .i_y_start       (i_y_start),
        .i_x_end         (i_x_end),
        .i_y_end         (i_y_end),
        .i_x_shift       (i_x_shift),
        .i_y_shift       (i_y_shift),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_thickness     (i_thickness),
        .i_swap_bytes    (i_swap_bytes),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_write_enable  (o_write_enable),
        .o_line_done     (o_line_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_raster_state();
        fb_width   = FRAME_BITS'(FRAME_RESET);
        fb_height  = FRAME_BITS'(FRAME_RESET);
        pos_x      = '0;
        pos_y      = '0;
        goal_x     = '0;
        goal_y     = '0;
        run_x      = '0;
        run_y      = '0;
        step_x_neg = 1'b0;
        step_y_neg = 1'b0;
        err_acc    = '0;
        col_cnt    = '0;
        row_cnt    = '0;
        half       = '0;
        color_reg  = '0;
        drawing    = 1'b0;
    endfunction

    // returns 1 for a load or a step that yields a pixel write
    function automatic bit rasterize(t_raster_cmd c);
        int                    x1, y1, x2, y2, th;
        int                    px, py, h, side, e2;
        logic [COLOR_BITS-1:0] rgb;
        bit                    last;
        t_result               r;
        if (c.opcode == OP_LOAD) begin
            x1 = int'(c.x_start) + int'(c.x_shift);
            y1 = int'(c.y_start) + int'(c.y_shift);
            x2 = int'(c.x_end) + int'(c.x_shift);
            y2 = int'(c.y_end) + int'(c.y_shift);
            th = (int'(c.thickness) > MAX_THICKNESS) ? MAX_THICKNESS : int'(c.thickness);
            rgb = {c.red[7:3], c.green[7:2], c.blue[7:3]};
            if (c.swap_bytes) begin
                rgb = {rgb[7:0], rgb[15:8]};
            end
            pos_x      = POS_BITS'(x1);
            pos_y      = POS_BITS'(y1);
            goal_x     = POS_BITS'(x2);
            goal_y     = POS_BITS'(y2);
            run_x      = POS_BITS'((x2 >= x1) ? x2 - x1 : x1 - x2);
            run_y      = POS_BITS'((y2 >= y1) ? y2 - y1 : y1 - y2);
            step_x_neg = !(x1 < x2);
            step_y_neg = !(y1 < y2);
            err_acc    = ERR_BITS'(int'(run_x) - int'(run_y));
            half       = HALF_BITS'(th / 2);
            col_cnt    = '0;
            row_cnt    = '0;
            color_reg  = rgb;
            drawing    = 1'b1;
            return 1'b1;
        end
        if (!drawing) begin
            return 1'b0;
        end
        h  = int'(half);
        px = int'(pos_x) + int'(col_cnt) - h;
        py = int'(pos_y) + int'(row_cnt) - h;
        r.write_enable  = px >= 0 && py >= 0 && px < int'(fb_width) && py < int'(fb_height);
        r.pixel_address = '0;
        if (r.write_enable) begin
            r.pixel_address = ADDR_BITS'(longint'(py) * longint'(fb_width) + longint'(px));
        end
        r.pixel_color = color_reg;
        r.line_done   = 1'b0;
        side = 2 * h;
        last = 1'b0;
        if (int'(col_cnt) < side) begin
            col_cnt++;
        end else begin
            col_cnt = '0;
            if (int'(row_cnt) < side) begin
                row_cnt++;
            end else begin
                row_cnt = '0;
                last    = 1'b1;
            end
        end
        if (last) begin
            if (pos_x == goal_x && pos_y == goal_y) begin
                r.line_done = 1'b1;
                drawing     = 1'b0;
            end else begin
                e2 = int'(err_acc) * 2;
                if (e2 > -int'(run_y)) begin
                    err_acc = ERR_BITS'(int'(err_acc) - int'(run_y));
                    pos_x   = step_x_neg ? pos_x - POS_BITS'(1) : pos_x + POS_BITS'(1);
                end
                if (e2 < int'(run_x)) begin
                    err_acc = ERR_BITS'(int'(err_acc) + int'(run_x));
                    pos_y   = step_y_neg ? pos_y - POS_BITS'(1) : pos_y + POS_BITS'(1);
                end
            end
        end
        pixel_writes_due.push_back(r);
        return 1'b1;
    endfunction

    function automatic t_raster_cmd random_cmd(t_opcode op);
        t_raster_cmd c;
        c.opcode     = op;
        c.x_start    = COORD_BITS'($urandom);
        c.y_start    = COORD_BITS'($urandom);
        c.x_end      = COORD_BITS'($urandom);
        c.y_end      = COORD_BITS'($urandom);
        c.x_shift    = COORD_BITS'($urandom);
        c.y_shift    = COORD_BITS'($urandom);
        c.red        = 8'($urandom);
        c.green      = 8'($urandom);
        c.blue       = 8'($urandom);
        c.thickness  = THICK_BITS'($urandom);
        c.swap_bytes = 1'($urandom);
        return c;
    endfunction

    function automatic t_raster_cmd make_load(int xs, int ys, int xe, int ye, int xsh,
                                              int ysh, int r, int g, int b, int th, int sw);
        t_raster_cmd c;
        c.opcode     = OP_LOAD;
        c.x_start    = COORD_BITS'(xs);
        c.y_start    = COORD_BITS'(ys);
        c.x_end      = COORD_BITS'(xe);
        c.y_end      = COORD_BITS'(ye);
        c.x_shift    = COORD_BITS'(xsh);
        c.y_shift    = COORD_BITS'(ysh);
        c.red        = 8'(r);
        c.green      = 8'(g);
        c.blue       = 8'(b);
        c.thickness  = THICK_BITS'(th);
        c.swap_bytes = 1'(sw);
        return c;
    endfunction

    task automatic send_cmd(t_raster_cmd c);
        @(negedge i_clk);
        while (tx_idle_en && $urandom_range(0, 99) < 33) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode     = c.opcode;
        i_x_start    = c.x_start;
        i_y_start    = c.y_start;
        i_x_end      = c.x_end;
        i_y_end      = c.y_end;
        i_x_shift    = c.x_shift;
        i_y_shift    = c.y_shift;
        i_red        = c.red;
        i_green      = c.green;
        i_blue       = c.blue;
        i_thickness  = c.thickness;
        i_swap_bytes = c.swap_bytes;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (rasterize(c)) begin
            work_items++;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pixel_writes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, int val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = FRAME_BITS'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_FRAME_WIDTH) begin
            fb_width = FRAME_BITS'(val);
        end else begin
            fb_height = FRAME_BITS'(val);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_frame(int w, int h);
        drain_results();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // one axis of a short line, often placed around the frame edges
    task automatic pick_axis(input int lim, input int d,
                             output logic signed [COORD_BITS-1:0] p0,
                             output logic signed [COORD_BITS-1:0] p1,
                             output logic signed [COORD_BITS-1:0] sh);
        int t, lo, hi, s0, e, shv;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 2))
                0: t = int'($urandom_range(0, 8)) - 4;
                1: t = lim + int'($urandom_range(0, 8)) - 4;
                default: t = int'($urandom_range(0, lim));
            endcase
            if (t > 4094) begin
                t = 4094;
            end
            lo  = (t - 2047 > -2048) ? t - 2047 : -2048;
            hi  = (t + 2048 < 2047) ? t + 2048 : 2047;
            shv = lo + int'($urandom_range(0, hi - lo));
            s0  = t - shv;
        end else begin
            s0  = int'($urandom_range(0, 4095)) - 2048;
            shv = int'($urandom_range(0, 4095)) - 2048;
        end
        e = ($urandom_range(0, 1) != 0) ? s0 + d : s0 - d;
        if (e > 2047) begin
            e = s0 - d;
        end
        if (e < -2048) begin
            e = s0 + d;
        end
        p0 = COORD_BITS'(s0);
        p1 = COORD_BITS'(e);
        sh = COORD_BITS'(shv);
    endtask

    task automatic draw_random_line();
        t_raster_cmd c;
        int          h, cap, dx, dy, pts, n;
        c = random_cmd(OP_LOAD);
        h = int'(c.thickness) / 2;
        case (h)
            0: cap = ($urandom_range(0, 9) == 0) ? 120 : 30;
            1: cap = 10;
            2: cap = 5;
            default: cap = 3;
        endcase
        dx = int'($urandom_range(0, cap));
        dy = int'($urandom_range(0, cap));
        case ($urandom_range(0, 4))
            0: dx = 0;
            1: dy = 0;
            2: dy = dx;
            default: ;
        endcase
        pick_axis(int'(fb_width), dx, c.x_start, c.x_end, c.x_shift);
        pick_axis(int'(fb_height), dy, c.y_start, c.y_end, c.y_shift);
        pts = ((dx > dy ? dx : dy) + 1) * (2 * h + 1) * (2 * h + 1);
        // cut lines get replaced by the next load, overlong ones hit an idle block
        case ($urandom_range(0, 9))
            0: n = int'($urandom_range(0, pts - 1));
            1: n = pts + int'($urandom_range(1, 3));
            default: n = pts;
        endcase
        send_cmd(c);
        repeat (n) send_cmd(random_cmd(OP_STEP));
    endtask

    task automatic run_lines(int goal);
        int stop_at;
        stop_at = work_items + goal;
        while (work_items < stop_at) draw_random_line();
    endtask

    task automatic test_directed();
        send_cmd(random_cmd(OP_STEP));
        send_cmd(make_load(0, 0, 0, 0, 0, 0, 255, 0, 255, 0, 0));
        repeat (2) send_cmd(random_cmd(OP_STEP));
        send_cmd(make_load(0, 0, 0, 0, 0, 0, 255, 255, 255, 3, 1));
        repeat (9) send_cmd(random_cmd(OP_STEP));
        send_cmd(make_load(-2048, 2047, 2047, -2048, -2048, 2047, 0, 0, 0, 7, 1));
        repeat (3) send_cmd(random_cmd(OP_STEP));
        send_cmd(make_load(2047, -2048, -2048, 2047, 2047, -2048, 8, 4, 8, 6, 0));
        repeat (3) send_cmd(random_cmd(OP_STEP));
        send_cmd(make_load(239, 239, 240, 240, 0, 0, 128, 128, 128, 1, 0));
        repeat (2) send_cmd(random_cmd(OP_STEP));
        drain_results();
    endtask

    task automatic test_frame_sizes();
        int widths[8]  = '{1, 0, 4095, 2048, 4095, 5, 240, 0};
        int heights[8] = '{1, 0, 4095, 2047, 3, 4095, 240, 0};
        widths[7]  = int'($urandom_range(1, 2048));
        heights[7] = int'($urandom_range(1, 2048));
        foreach (widths[k]) begin
            set_frame(widths[k], heights[k]);
            run_lines(8);
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        set_frame(240, 240);
        run_lines(60);
        drain_results();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_lines(100);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        drain_results();
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_cmd(make_load(0, 0, 200, 60, 0, 0, 200, 100, 50, 0, 0));
        hold_len = HOLD_CYCLES;
        repeat (120) send_cmd(random_cmd(OP_STEP));
        drain_results();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver side, with an optional long hold-off
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_out_ready = 1'b0;
                hold_len--;
            end else if (rx_idle_en) begin
                i_out_ready = ($urandom_range(0, 99) >= 33);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_pixel_address, o_pixel_color, o_write_enable, o_line_done};
                if (pixel_writes_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected pixel write: addr %0d color %h we %b done %b",
                                 got.pixel_address, got.pixel_color, got.write_enable,
                                 got.line_done);
                    end
                end else begin
                    want = pixel_writes_due.pop_front();
                    if (got.pixel_address !== want.pixel_address ||
                        got.pixel_color !== want.pixel_color ||
                        got.write_enable !== want.write_enable ||
                        got.line_done !== want.line_done) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("pixel write mismatch: exp addr %0d color %h we %b done %b",
                                     want.pixel_address, want.pixel_color,
                                     want.write_enable, want.line_done);
                            $display("                      got addr %0d color %h we %b done %b",
                                     got.pixel_address, got.pixel_color,
                                     got.write_enable, got.line_done);
                        end
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_FRAME_WIDTH;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_LOAD;
        i_x_start      = '0;
        i_y_start      = '0;
        i_x_end        = '0;
        i_y_end        = '0;
        i_x_shift      = '0;
        i_y_shift      = '0;
        i_red          = '0;
        i_green        = '0;
        i_blue         = '0;
        i_thickness    = '0;
        i_swap_bytes   = 1'b0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        hold_len       = 0;
        mismatch_count = 0;
        work_items     = 0;
        clear_raster_state();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_frame_sizes();
        test_random_traffic();
        test_backpressure();

        drain_results();
        if (mismatch_count == 0 && pixel_writes_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
